// ----- src/assert_macros.svh -----
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- src/stw_pkg.sv -----
// types, constants and helper functions of the sigil text to binary writer
package stw_pkg;

    localparam logic [7:0] CH_BYTE   = 8'h7E;
    localparam logic [7:0] CH_SHORT  = 8'h21;
    localparam logic [7:0] CH_INT    = 8'h3F;
    localparam logic [7:0] CH_LONG   = 8'h26;
    localparam logic [7:0] CH_CHAR   = 8'h5E;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] SIGN_FILL = 8'hFF;

    localparam logic [1:0] RK_DATA  = 2'd0;
    localparam logic [1:0] RK_ERROR = 2'd1;
    localparam logic [1:0] RK_END   = 2'd2;

    localparam logic [1:0] FMT_BYTE  = 2'd0;
    localparam logic [1:0] FMT_SHORT = 2'd1;
    localparam logic [1:0] FMT_INT   = 2'd2;
    localparam logic [1:0] FMT_LONG  = 2'd3;

    typedef enum logic [6:0] {
        MODE_IDLE     = 7'b0000001,
        MODE_NUM      = 7'b0000010,
        MODE_CHAR     = 7'b0000100,
        MODE_CHAR_ESC = 7'b0001000,
        MODE_STR      = 7'b0010000,
        MODE_STR_ESC  = 7'b0100000,
        MODE_HALT     = 7'b1000000
    } mode_t;

    typedef enum logic [1:0] {
        TAIL_NONE,
        TAIL_BYTE,
        TAIL_ERR,
        TAIL_END
    } tail_t;

    typedef struct packed {
        logic        has_flush;
        logic [1:0]  fmt;
        logic [31:0] value;
        tail_t       tail;
        logic [7:0]  tail_byte;
    } cmd_t;

    function automatic logic [7:0] unescape(input logic [7:0] c);
        logic [7:0] r;
        case (c)
            "a", "A": r = 8'd7;
            "b", "B": r = 8'd8;
            "f", "F": r = 8'd12;
            "n", "N": r = 8'd10;
            "r", "R": r = 8'd13;
            "t", "T": r = 8'd9;
            "v", "V": r = 8'd11;
            "0":      r = 8'd0;
            default:  r = c;
        endcase
        return r;
    endfunction

    function automatic logic [3:0] flush_len(input logic [1:0] fmt);
        logic [3:0] n;
        case (fmt)
            FMT_BYTE:  n = 4'd1;
            FMT_SHORT: n = 4'd2;
            FMT_INT:   n = 4'd4;
            default:   n = 4'd8;
        endcase
        return n;
    endfunction

endpackage

// ----- src/stw_in_if.sv -----
// text character channel
interface stw_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] text_char;

    modport source (output valid, output kind, output text_char, input ready);
    modport sink (input valid, input kind, input text_char, output ready);
endinterface

// ----- src/stw_out_if.sv -----
// binary result channel
interface stw_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] result_kind;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, output result_kind, output out_byte, output last,
                    input ready);
    modport sink (input valid, input result_kind, input out_byte, input last,
                  output ready);
endinterface

// ----- src/stw_front.sv -----
// parser: accepts text characters, tracks the parse mode and issues output commands
`include "assert_macros.svh"

module stw_front (
    input  logic          clk,
    input  logic          rst_n,
    stw_in_if.sink        text,
    input  logic          full,
    output logic          push,
    output stw_pkg::cmd_t cmd
);
    import stw_pkg::*;

    mode_t       mode_reg, mode_next;
    logic [1:0]  fmt_reg, fmt_next;
    logic [31:0] value_reg, value_next;
    logic        accept;
    logic        is_digit;
    logic        sig_known;
    mode_t       sig_mode;
    logic [1:0]  sig_fmt;
    logic [7:0]  c;

    assign text.ready = !full;
    assign accept     = text.valid && text.ready;
    assign c          = text.text_char;
    assign is_digit   = c inside {[CH_ZERO:CH_NINE]};

    always_comb
    begin
        sig_known = 1'b1;
        sig_mode  = MODE_NUM;
        sig_fmt   = fmt_reg;
        case (c)
            CH_BYTE:  sig_fmt = FMT_BYTE;
            CH_SHORT: sig_fmt = FMT_SHORT;
            CH_INT:   sig_fmt = FMT_INT;
            CH_LONG:  sig_fmt = FMT_LONG;
            CH_CHAR:  sig_mode = MODE_CHAR;
            CH_QUOTE: sig_mode = MODE_STR;
            default:
            begin
                sig_known = 1'b0;
                sig_mode  = MODE_HALT;
            end
        endcase
    end

    always_comb
    begin
        mode_next     = mode_reg;
        fmt_next      = fmt_reg;
        value_next    = value_reg;
        cmd.has_flush = 1'b0;
        cmd.fmt       = fmt_reg;
        cmd.value     = value_reg;
        cmd.tail      = TAIL_NONE;
        cmd.tail_byte = c;
        if (text.kind)
        begin
            cmd.has_flush = (mode_reg == MODE_NUM);
            cmd.tail      = TAIL_END;
            mode_next     = MODE_IDLE;
            value_next    = '0;
        end
        else
        begin
            case (mode_reg)
                MODE_NUM:
                begin
                    if (is_digit)
                    begin
                        value_next = (value_reg << 3) + (value_reg << 1) + {28'd0, c[3:0]};
                    end
                    else
                    begin
                        cmd.has_flush = 1'b1;
                        value_next    = '0;
                        mode_next     = sig_mode;
                        fmt_next      = sig_fmt;
                        if (!sig_known)
                        begin
                            cmd.tail = TAIL_ERR;
                        end
                    end
                end
                MODE_CHAR:
                begin
                    if (c == CH_BSLASH)
                    begin
                        mode_next = MODE_CHAR_ESC;
                    end
                    else
                    begin
                        cmd.tail  = TAIL_BYTE;
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_CHAR_ESC:
                begin
                    cmd.tail      = TAIL_BYTE;
                    cmd.tail_byte = unescape(c);
                    mode_next     = MODE_IDLE;
                end
                MODE_STR:
                begin
                    if (c == CH_BSLASH)
                    begin
                        mode_next = MODE_STR_ESC;
                    end
                    else if (c == CH_QUOTE)
                    begin
                        mode_next = MODE_IDLE;
                    end
                    else
                    begin
                        cmd.tail = TAIL_BYTE;
                    end
                end
                MODE_STR_ESC:
                begin
                    cmd.tail      = TAIL_BYTE;
                    cmd.tail_byte = unescape(c);
                    mode_next     = MODE_STR;
                end
                MODE_HALT:
                begin
                    mode_next = MODE_HALT;
                end
                default:
                begin
                    value_next = '0;
                    mode_next  = sig_mode;
                    fmt_next   = sig_fmt;
                    if (!sig_known)
                    begin
                        cmd.tail = TAIL_ERR;
                    end
                end
            endcase
        end
    end

    assign push = accept && (cmd.has_flush || (cmd.tail != TAIL_NONE));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            fmt_reg   <= FMT_BYTE;
            value_reg <= '0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            fmt_reg   <= fmt_next;
            value_reg <= value_next;
        end
    end

    // a number only accumulates while a number is open
    `ASSERT_IMPLIES(a_value_only_in_number, clk, rst_n, mode_reg != MODE_NUM, value_reg == '0)

endmodule

// ----- src/stw_queue.sv -----
// command queue between parser and byte emitter
`include "assert_macros.svh"

module stw_queue #(
    parameter int DEPTH = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  stw_pkg::cmd_t wr_cmd,
    input  logic          pop,
    output logic          full,
    output logic          head_valid,
    output stw_pkg::cmd_t head_cmd
);
    import stw_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

    `ASSERT_IMPLIES(a_pop_not_empty, clk, rst_n, pop, count_reg != '0)
    `ASSERT_NEXT(a_push_counts, clk, rst_n, push && !pop,
                 count_reg == CNT_W'($past(count_reg) + 1'b1))

endmodule

// ----- src/stw_back.sv -----
// byte emitter: expands queued commands into result transactions
`include "assert_macros.svh"

module stw_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          head_valid,
    input  stw_pkg::cmd_t head_cmd,
    output logic          pop,
    stw_out_if.source     result
);
    import stw_pkg::*;

    logic [3:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic [1:0] kind_reg;
    logic [7:0] byte_reg;
    logic       last_reg;

    logic       load;
    logic [3:0] nflush;
    logic [3:0] total;
    logic       final_byte;
    logic [1:0] sel;
    logic [7:0] num_byte;
    logic [1:0] cur_kind;
    logic [7:0] cur_byte;

    assign load   = !valid_reg || result.ready;
    assign nflush = head_cmd.has_flush ? flush_len(head_cmd.fmt) : 4'd0;
    assign total  = nflush + {3'd0, head_cmd.tail != TAIL_NONE};
    assign final_byte = (idx_reg + 1'b1) == total;
    assign pop    = load && head_valid && final_byte;

    always_comb
    begin
        case (head_cmd.fmt)
            FMT_BYTE:  sel = 2'd0;
            FMT_SHORT: sel = {1'b0, ~idx_reg[0]};
            FMT_INT:   sel = idx_reg[1:0];
            default:   sel = ~idx_reg[1:0];
        endcase
        num_byte = head_cmd.value[{sel, 3'b000} +: 8];
        if (head_cmd.fmt == FMT_LONG && !idx_reg[2])
        begin
            num_byte = head_cmd.value[31] ? SIGN_FILL : 8'h00;
        end
    end

    always_comb
    begin
        cur_kind = RK_DATA;
        cur_byte = num_byte;
        if (idx_reg >= nflush)
        begin
            case (head_cmd.tail)
                TAIL_ERR:
                begin
                    cur_kind = RK_ERROR;
                    cur_byte = 8'h00;
                end
                TAIL_END:
                begin
                    cur_kind = RK_END;
                    cur_byte = 8'h00;
                end
                default:
                begin
                    cur_byte = head_cmd.tail_byte;
                end
            endcase
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (load)
        begin
            valid_next = head_valid;
            if (head_valid)
            begin
                idx_next = final_byte ? 4'd0 : idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && head_valid)
        begin
            kind_reg <= cur_kind;
            byte_reg <= cur_byte;
            last_reg <= final_byte;
        end
    end

    assign result.valid       = valid_reg;
    assign result.result_kind = kind_reg;
    assign result.out_byte    = byte_reg;
    assign result.last        = last_reg;

    // mid-command position means the command is still at the head
    `ASSERT_IMPLIES(a_idx_has_head, clk, rst_n, idx_reg != '0, head_valid)

endmodule

// ----- src/sigil_text_to_binary_writer.sv -----
// Sigil text to binary writer. One text character or end of text is taken per
// cycle as long as the command queue (QUEUE_DEPTH entries) has room; the parser
// turns each into at most one command. The emitter drains the queue at one result
// transaction per cycle while the receiver is ready: a flushed number gives 1, 2, 4
// or 8 bytes, followed by an optional data byte, error or end marker, so one input
// yields up to 9 results. Sustained input rate is one per cycle while results average
// one per input; long numbers are absorbed by the queue and the output register.
module sigil_text_to_binary_writer #(
    parameter int QUEUE_DEPTH = 4
) (
    input logic       clk,
    input logic       rst_n,
    stw_in_if.sink    text,
    stw_out_if.source result
);
    import stw_pkg::*;

    logic full;
    logic push;
    logic pop;
    logic head_valid;
    cmd_t wr_cmd;
    cmd_t head_cmd;

    stw_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .text  (text),
        .full  (full),
        .push  (push),
        .cmd   (wr_cmd)
    );

    stw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .wr_cmd     (wr_cmd),
        .pop        (pop),
        .full       (full),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    stw_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .result     (result)
    );

endmodule

// ----- dv/stw_byte_stream_monitor.sv -----
`timescale 1ns / 1ps
// watches both channels of the sigil writer, predicts each result and compares it
module stw_byte_stream_monitor (
    input  logic        clk,
    input  logic        rst_n,
    stw_in_if           text,
    stw_out_if          result,
    output int unsigned failures,
    output int unsigned pending,
    output int unsigned checked
);
    import stw_pkg::*;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       last;
    } result_t;

    mode_t       mode = MODE_IDLE;
    logic [1:0]  fmt = FMT_BYTE;
    logic [31:0] acc = '0;
    result_t     expected_bytes[$];

    function automatic void push_expected(logic [1:0] k, logic [7:0] d);
        result_t r;
        r.kind = k;
        r.data = d;
        r.last = 1'b0;
        expected_bytes = {expected_bytes, r};
    endfunction

    function automatic void flush_value();
        logic [7:0] fill;
        fill = acc[31] ? SIGN_FILL : 8'h00;
        case (fmt)
            FMT_BYTE:
                push_expected(RK_DATA, acc[7:0]);
            FMT_SHORT:
            begin
                push_expected(RK_DATA, acc[15:8]);
                push_expected(RK_DATA, acc[7:0]);
            end
            FMT_INT:
            begin
                for (int i = 0; i < 4; i++)
                    push_expected(RK_DATA, acc[8*i +: 8]);
            end
            default:
            begin
                for (int i = 0; i < 4; i++)
                    push_expected(RK_DATA, fill);
                for (int i = 3; i >= 0; i--)
                    push_expected(RK_DATA, acc[8*i +: 8]);
            end
        endcase
        acc = '0;
    endfunction

    function automatic logic [7:0] escaped_byte(logic [7:0] c);
        logic [7:0] folded;
        logic [7:0] r;
        folded = (c >= "A" && c <= "Z") ? (c | 8'h20) : c;
        case (folded)
            "a":     r = 8'd7;
            "b":     r = 8'd8;
            "f":     r = 8'd12;
            "n":     r = 8'd10;
            "r":     r = 8'd13;
            "t":     r = 8'd9;
            "v":     r = 8'd11;
            "0":     r = 8'd0;
            default: r = c;
        endcase
        return r;
    endfunction

    function automatic void open_unit(logic [7:0] c);
        acc = '0;
        case (c)
            CH_BYTE:
            begin
                mode = MODE_NUM;
                fmt = FMT_BYTE;
            end
            CH_SHORT:
            begin
                mode = MODE_NUM;
                fmt = FMT_SHORT;
            end
            CH_INT:
            begin
                mode = MODE_NUM;
                fmt = FMT_INT;
            end
            CH_LONG:
            begin
                mode = MODE_NUM;
                fmt = FMT_LONG;
            end
            CH_CHAR:
                mode = MODE_CHAR;
            CH_QUOTE:
                mode = MODE_STR;
            default:
            begin
                push_expected(RK_ERROR, 8'h00);
                mode = MODE_HALT;
            end
        endcase
    endfunction

    function automatic void predict_transaction(logic k, logic [7:0] c);
        int base;
        base = expected_bytes.size();
        if (k)
        begin
            if (mode == MODE_NUM)
                flush_value();
            mode = MODE_IDLE;
            acc = '0;
            push_expected(RK_END, 8'h00);
        end
        else
        begin
            case (mode)
                MODE_NUM:
                    if (c >= CH_ZERO && c <= CH_NINE)
                        acc = acc * 32'd10 + 32'(c - CH_ZERO);
                    else
                    begin
                        flush_value();
                        open_unit(c);
                    end
                MODE_CHAR:
                    if (c == CH_BSLASH)
                        mode = MODE_CHAR_ESC;
                    else
                    begin
                        push_expected(RK_DATA, c);
                        mode = MODE_IDLE;
                    end
                MODE_CHAR_ESC:
                begin
                    push_expected(RK_DATA, escaped_byte(c));
                    mode = MODE_IDLE;
                end
                MODE_STR:
                    if (c == CH_BSLASH)
                        mode = MODE_STR_ESC;
                    else if (c == CH_QUOTE)
                        mode = MODE_IDLE;
                    else
                        push_expected(RK_DATA, c);
                MODE_STR_ESC:
                begin
                    push_expected(RK_DATA, escaped_byte(c));
                    mode = MODE_STR;
                end
                MODE_HALT:
                    ;
                default:
                    open_unit(c);
            endcase
        end
        if (expected_bytes.size() > base)
            expected_bytes[expected_bytes.size() - 1].last = 1'b1;
    endfunction

    function automatic void compare_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            failures++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode = MODE_IDLE;
            fmt = FMT_BYTE;
            acc = '0;
            expected_bytes.delete();
            failures = 0;
            pending = 0;
            checked = 0;
        end
        else
        begin
            result_t want;
            if (text.valid && text.ready)
                predict_transaction(text.kind, text.text_char);
            if (result.valid && result.ready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    failures++;
                    $display("%0t: unexpected result, expected none, %s %0d byte %0d last %0d",
                             $time, "actual kind", result.result_kind, result.out_byte,
                             result.last);
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    checked++;
                    compare_field("result_kind", 8'(want.kind), 8'(result.result_kind));
                    compare_field("out_byte", want.data, result.out_byte);
                    compare_field("last", 8'(want.last), 8'(result.last));
                end
            end
            pending = expected_bytes.size();
        end
    end

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// top of the sigil writer testbench: clock, reset, text stimulus and verdict
module testbench;
    import stw_pkg::*;

    logic        clk;
    logic        rst_n;
    bit          idling_on;
    bit          hold_done;
    int unsigned hold_cycles;
    int unsigned items_sent;
    int unsigned ends_sent;
    int unsigned failures;
    int unsigned pending;
    int unsigned checked;

    logic [7:0] openers [6] = '{CH_BYTE, CH_SHORT, CH_INT, CH_LONG, CH_CHAR, CH_QUOTE};
    string      esc_letters = "abfnrtvABFNRTV0";

    stw_in_if  text_ch ();
    stw_out_if result_ch ();

    sigil_text_to_binary_writer dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text_ch),
        .result (result_ch)
    );

    stw_byte_stream_monitor stream_mon (
        .clk      (clk),
        .rst_n    (rst_n),
        .text     (text_ch),
        .result   (result_ch),
        .failures (failures),
        .pending  (pending),
        .checked  (checked)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    initial
    begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

    // called just after a falling edge, returns just after a falling edge once the character is taken
    task automatic send_text(input logic k, input logic [7:0] c);
        while (idling_on && $urandom_range(99) < 7)
        begin
            text_ch.valid <= 1'b0;
            @(negedge clk);
        end
        text_ch.valid <= 1'b1;
        text_ch.kind <= k;
        text_ch.text_char <= c;
        do
            @(posedge clk);
        while (!text_ch.ready);
        items_sent++;
        if (k)
            ends_sent++;
        @(negedge clk);
    endtask

    function automatic logic [7:0] random_escape();
        if ($urandom_range(1))
            return esc_letters[$urandom_range(14)];
        return 8'($urandom_range(255));
    endfunction

    // receiver side
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles != 0)
            begin
                result_ch.ready <= 1'b0;
                hold_cycles--;
            end
            else
                result_ch.ready <= !(idling_on && $urandom_range(99) < 7);
        end
    end

    initial
    begin
        int unsigned pick;
        int unsigned n;
        logic [7:0]  c;

        rst_n = 1'b0;
        text_ch.valid = 1'b0;
        text_ch.kind = 1'b0;
        text_ch.text_char = 8'h00;
        idling_on = 1'b1;
        hold_done = 1'b0;
        hold_cycles = 0;
        items_sent = 0;
        ends_sent = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // each unit, escapes, edge bytes, error halt and end of text cases
        send_text(1'b0, CH_BYTE);
        send_text(1'b0, "9");
        send_text(1'b0, CH_SHORT);
        send_text(1'b0, CH_INT);
        send_text(1'b0, CH_LONG);
        send_text(1'b0, "7");
        send_text(1'b0, CH_CHAR);
        send_text(1'b0, CH_BSLASH);
        send_text(1'b0, "n");
        send_text(1'b0, CH_QUOTE);
        send_text(1'b0, 8'h00);
        send_text(1'b0, CH_BSLASH);
        send_text(1'b0, "q");
        send_text(1'b0, CH_QUOTE);
        send_text(1'b0, CH_CHAR);
        send_text(1'b0, 8'hFF);
        send_text(1'b0, CH_BYTE);
        send_text(1'b0, "3");
        send_text(1'b0, "Z");
        send_text(1'b0, "1");
        send_text(1'b1, 8'hFF);
        send_text(1'b0, CH_CHAR);
        send_text(1'b1, 8'h00);
        send_text(1'b0, CH_QUOTE);
        send_text(1'b0, "b");
        send_text(1'b1, 8'h00);
        send_text(1'b0, CH_LONG);
        send_text(1'b0, "5");
        send_text(1'b1, 8'h00);

        while (items_sent < 280)
        begin
            if (!hold_done && items_sent >= 120)
            begin
                hold_cycles = 80;
                hold_done = 1'b1;
            end
            idling_on = !(items_sent >= 170 && items_sent < 240);
            pick = $urandom_range(99);
            if (pick < 80)
            begin
                case ($urandom_range(2))
                    0:
                    begin
                        send_text(1'b0, openers[$urandom_range(3)]);
                        n = ($urandom_range(3) == 0) ? $urandom_range(12, 8) : $urandom_range(3);
                        repeat (n) send_text(1'b0, CH_ZERO + 8'($urandom_range(9)));
                    end
                    1:
                    begin
                        send_text(1'b0, CH_CHAR);
                        if ($urandom_range(3) == 0)
                        begin
                            send_text(1'b0, CH_BSLASH);
                            send_text(1'b0, random_escape());
                        end
                        else
                            send_text(1'b0, 8'($urandom_range(255)));
                    end
                    default:
                    begin
                        send_text(1'b0, CH_QUOTE);
                        n = $urandom_range(6);
                        repeat (n)
                        begin
                            if ($urandom_range(4) == 0)
                            begin
                                send_text(1'b0, CH_BSLASH);
                                send_text(1'b0, random_escape());
                            end
                            else
                            begin
                                c = 8'($urandom_range(255));
                                if (c == CH_QUOTE || c == CH_BSLASH)
                                    c = 8'h20;
                                send_text(1'b0, c);
                            end
                        end
                        send_text(1'b0, CH_QUOTE);
                    end
                endcase
            end
            else if (pick < 88)
                send_text(1'b1, 8'($urandom_range(255)));
            else if (pick < 95)
            begin
                // noise byte, most likely an unknown sigil, then text until end
                send_text(1'b0, 8'($urandom_range(255)));
                n = $urandom_range(2);
                repeat (n) send_text(1'b0, 8'($urandom_range(255)));
                send_text(1'b1, 8'($urandom_range(255)));
            end
            else
            begin
                // unit cut short by end of text
                send_text(1'b0, openers[$urandom_range(5)]);
                send_text(1'b1, 8'($urandom_range(255)));
            end
        end
        idling_on = 1'b1;
        text_ch.valid <= 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);

        $display("run covered %0d text transactions including %0d end of text markers,",
                 items_sent, ends_sent);
        $display("with %0d result transactions compared against the prediction", checked);
        if (failures == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
